### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define WSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define WSD_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/wsd_pkg.sv
// Types and constants of the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned LenW = 24;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  localparam logic ERR_UPPER_BYTES = 1'b0;
  localparam logic ERR_TOO_LONG    = 1'b1;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [LenW-1:0] MAX_PAYLOAD_RESET = 24'h100000;

  // Byte positions inside the extended length and the mask key.
  localparam logic [2:0] EXT16_BYTES     = 3'd2;
  localparam logic [2:0] EXT64_UPPER     = 3'd5;
  localparam logic [2:0] EXT64_LAST_IDX  = 3'd7;
  localparam logic [2:0] MASK_KEY_BYTES  = 3'd4;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      fin_opcode;
    logic [LenW-1:0] frame_len;
    logic [7:0]      data;
    logic            last;
    logic            error_code;
  } res_t;

endpackage

### rtl/wsd_parser.sv
// Header parser and payload unmasker: one byte per transfer, one result at most.
`include "assert_macros.svh"

module wsd_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               rx_byte_i,
  input  logic                     cfg_we_i,
  input  logic [wsd_pkg::LenW-1:0] cfg_wdata_i,
  output logic                     res_valid_o,
  output wsd_pkg::res_t            res_o
);
  import wsd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [7:0]      first_q, first_d;
  logic            mask_on_q, mask_on_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [31:0]     key_q, key_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [1:0]      idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic [LenW-1:0] max_q;

  logic            len_done;
  logic            hdr;
  logic [7:0]      key_byte;

  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    mask_on_d   = mask_on_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    key_d       = key_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    len_done    = 1'b0;
    hdr         = 1'b0;
    key_byte    = 8'd0;
    res_valid_o = 1'b0;
    res_o.kind       = KIND_HEADER;
    res_o.data       = 8'd0;
    res_o.last       = 1'b0;
    res_o.error_code = 1'b0;

    unique case (phase_q)
      PH_FIRST: begin
        first_d = rx_byte_i;
        phase_d = PH_SECOND;
      end
      PH_SECOND: begin
        mask_on_d = rx_byte_i[7];
        key_d     = '0;
        cnt_d     = '0;
        ovf_d     = 1'b0;
        len_d     = '0;
        if (rx_byte_i[6:0] == LEN7_EXT64) begin
          phase_d = PH_EXT64;
        end else if (rx_byte_i[6:0] == LEN7_EXT16) begin
          phase_d = PH_EXT16;
        end else begin
          len_d    = {{(LenW-7){1'b0}}, rx_byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT16: begin
        len_d = {len_q[LenW-9:0], rx_byte_i};
        cnt_d = cnt_q + 3'd1;
        len_done = (cnt_d >= EXT16_BYTES);
      end
      PH_EXT64: begin
        // Only the low three length bytes are kept; the upper five must be zero.
        if (cnt_q < EXT64_UPPER && rx_byte_i != 8'd0) begin
          ovf_d = 1'b1;
        end
        len_d = {len_q[LenW-9:0], rx_byte_i};
        if (cnt_q < EXT64_LAST_IDX) begin
          cnt_d = cnt_q + 3'd1;
        end else begin
          cnt_d    = '0;
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        key_d[{cnt_q[1:0], 3'b000} +: 8] = key_q[{cnt_q[1:0], 3'b000} +: 8] | rx_byte_i;
        cnt_d = cnt_q + 3'd1;
        if (cnt_d >= MASK_KEY_BYTES) begin
          cnt_d = '0;
          hdr   = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_byte    = mask_on_q ? key_q[{idx_q, 3'b000} +: 8] : 8'd0;
        idx_d       = idx_q + 2'd1;
        rem_d       = rem_q - 24'd1;
        if (rem_d == '0) begin
          phase_d = PH_FIRST;
        end
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DATA;
        res_o.data  = rx_byte_i ^ key_byte;
        res_o.last  = (rem_d == '0);
      end
      PH_ERROR: begin
        phase_d = PH_ERROR;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    if (len_done) begin
      if (ovf_d) begin
        phase_d          = PH_ERROR;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_UPPER_BYTES;
      end else if (len_d > max_q) begin
        phase_d          = PH_ERROR;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TOO_LONG;
      end else if (mask_on_d) begin
        phase_d = PH_MASK;
        cnt_d   = '0;
      end else begin
        hdr = 1'b1;
      end
    end

    if (hdr) begin
      rem_d       = len_d;
      idx_d       = '0;
      phase_d     = (len_d != '0) ? PH_PAYLOAD : PH_FIRST;
      res_valid_o = 1'b1;
      res_o.kind  = KIND_HEADER;
      res_o.last  = (len_d == '0);
    end

    res_o.fin_opcode = first_d;
    res_o.frame_len  = len_d;
    res_valid_o      = res_valid_o & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      first_q   <= '0;
      mask_on_q <= 1'b0;
      cnt_q     <= '0;
      len_q     <= '0;
      key_q     <= '0;
      rem_q     <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      mask_on_q <= mask_on_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      key_q     <= key_d;
      rem_q     <= rem_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  `WSD_ASSERT(a_error_sticky, clk_i, rst_ni, phase_q == PH_ERROR |=> phase_q == PH_ERROR, "error state left before reset")
  `WSD_ASSERT(a_data_in_payload, clk_i, rst_ni, (res_valid_o && res_o.kind == KIND_DATA) |-> phase_q == PH_PAYLOAD, "payload result outside payload phase")
  `WSD_NEVER(a_error_not_last, clk_i, rst_ni, res_valid_o && res_o.kind == KIND_ERROR && res_o.last, "error result marked last")

endmodule

### rtl/wsd_out_fifo.sv
// Two-entry result queue that decouples the parser from a stalled consumer.
`include "assert_macros.svh"

module wsd_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wsd_pkg::res_t out_data_o
);
  import wsd_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  `WSD_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "result pushed into a full queue")
  `WSD_ASSERT(a_count_up, clk_i, rst_ni, (push_i && !pop) |=> count_q == $past(count_q) + 2'd1, "queue count did not grow on push")
  `WSD_NEVER(a_count_range, clk_i, rst_ni, count_q == 2'd3, "queue count out of range")

endmodule

### rtl/websocket_frame_deframer.sv
// Each result is written into the result queue and offered on out_valid_o from there.
// Throughput: one byte per cycle while in_stall_o is low.
// A two-entry result queue lets bytes keep coming while a result waits to transfer.
// in_stall_o rises only when that queue is full.
// Reset: asynchronous, active low; parser waits for a first header byte, max_payload = 0x100000.
// An error result is sticky: later bytes are taken and dropped until reset.
module websocket_frame_deframer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wsd_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               fin_opcode_o,
  output logic [wsd_pkg::LenW-1:0] frame_len_o,
  output logic [7:0]               data_o,
  output logic                     last_o,
  output logic                     error_code_o
);
  import wsd_pkg::*;

  logic accept;
  logic res_valid;
  logic full;
  res_t res;
  res_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (head)
  );

  assign kind_o       = head.kind;
  assign fin_opcode_o = head.fin_opcode;
  assign frame_len_o  = head.frame_len;
  assign data_o       = head.data;
  assign last_o       = head.last;
  assign error_code_o = head.error_code;

endmodule
